@@ hdl/spq_pkg.sv @@
package spq_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int ID_BITS       = 16;
   localparam int PRIORITY_BITS = 8;

   localparam int SLOT_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] CMD_INSERT  = 3'd0;
   localparam logic [2:0] CMD_POP     = 3'd1;
   localparam logic [2:0] CMD_UPGRADE = 3'd2;
   localparam logic [2:0] CMD_CLEAR   = 3'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [ID_BITS-1:0]       id;
      logic [PRIORITY_BITS-1:0] pri;
   } entry_type;

   typedef struct packed {
      logic                 en;
      logic [SLOT_BITS-1:0] addr;
      entry_type            data;
   } wr_req_type;

endpackage

@@ hdl/spq_slot_ram.sv @@
module spq_slot_ram
   import spq_pkg::*;
(
   input  logic                 clock,
   input  wr_req_type           wr_req,
   input  logic [SLOT_BITS-1:0] rd_addr,
   output entry_type            rd_data
);

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_data_ff;

   // write one slot, read one slot; read data is registered and lands in the cycle after its address
   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.addr] <= wr_req.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/sorted_priority_queue_core.sv @@
// Sorted priority queue of QUEUE_DEPTH (id, priority) entries, lowest
// priority value served first, ties in arrival order. Raise start with a
// command while busy is low; busy then stays high until the result has
// been shown. The result is on the rsp_ ports for exactly one cycle with
// rsp_valid high and cannot be held off, so capture it in that cycle.
// The entries sit in a single-port-read slot memory walked by one
// compare-and-move sequencer: peek, clear and pop on an empty queue
// only read the front slot before answering, an insert into a full queue
// is dropped, an insert moves larger entries up one slot from the tail
// until the new entry fits, a pop pulls every later entry down one slot,
// and upgrade searches for its id, removes that slot if found and then
// inserts the entry anew. A new command is taken the cycle after the
// result strobe.
module sorted_priority_queue_core
   import spq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [2:0]               req_command,
   input  logic [ID_BITS-1:0]       req_item_id,
   input  logic [PRIORITY_BITS-1:0] req_priority_req,
   output logic                     rsp_valid,
   output logic                     rsp_front_valid,
   output logic [ID_BITS-1:0]       rsp_front_id,
   output logic [PRIORITY_BITS-1:0] rsp_front_priority,
   output logic [ID_BITS-1:0]       rsp_popped_id,
   output logic [CNT_BITS-1:0]      rsp_occupancy,
   output logic                     rsp_found,
   output logic [1:0]               rsp_status
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_INS_START = 4'd1;
   localparam logic [3:0] ST_INS_RD    = 4'd2;
   localparam logic [3:0] ST_INS_CMP   = 4'd3;
   localparam logic [3:0] ST_INS_PLACE = 4'd4;
   localparam logic [3:0] ST_POP_RD    = 4'd5;
   localparam logic [3:0] ST_POP_TAKE  = 4'd6;
   localparam logic [3:0] ST_RM        = 4'd7;
   localparam logic [3:0] ST_RM_WR     = 4'd8;
   localparam logic [3:0] ST_SRCH_RD   = 4'd9;
   localparam logic [3:0] ST_SRCH_CMP  = 4'd10;
   localparam logic [3:0] ST_FRONT_RD  = 4'd11;
   localparam logic [3:0] ST_RESP      = 4'd12;

   logic [3:0]               state_ff, state_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [SLOT_BITS-1:0]     idx_ff, idx_in;
   logic [2:0]               cmd_ff, cmd_in;
   entry_type                new_ff, new_in;
   logic [ID_BITS-1:0]       popped_ff, popped_in;
   logic                     found_ff, found_in;
   logic [1:0]               status_ff, status_in;

   wr_req_type               wr_req;
   logic [SLOT_BITS-1:0]     rd_addr;
   entry_type                rd_data;
   logic                     last_slot;
   logic                     have_front;

   spq_slot_ram u_slot_ram (
      .clock   (clock),
      .wr_req  (wr_req),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // idx sits on the last occupied slot
   assign last_slot  = (CNT_BITS'(idx_ff) + 1'b1) == count_ff;
   assign have_front = count_ff != '0;

   // pick the slot to read in this cycle
   always_comb begin
      unique case (state_ff)
         ST_RM:                 rd_addr = idx_ff + 1'b1;
         ST_POP_RD, ST_FRONT_RD: rd_addr = '0;
         default:               rd_addr = idx_ff;
      endcase
   end

   // sequence one command over the slot memory
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      cmd_in    = cmd_ff;
      new_in    = new_ff;
      popped_in = popped_ff;
      found_in  = found_ff;
      status_in = status_ff;
      wr_req    = '{en: 1'b0, addr: idx_ff, data: new_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in     = req_command;
               new_in.id  = req_item_id;
               new_in.pri = req_priority_req;
               popped_in  = '0;
               found_in   = 1'b0;
               status_in  = STATUS_OK;
               idx_in     = '0;
               case (req_command)
                  CMD_INSERT: state_in = ST_INS_START;
                  CMD_POP: begin
                     if (have_front) begin
                        state_in = ST_POP_RD;
                     end else begin
                        status_in = STATUS_EMPTY;
                        state_in  = ST_FRONT_RD;
                     end
                  end
                  CMD_UPGRADE: state_in = have_front ? ST_SRCH_RD : ST_INS_START;
                  CMD_CLEAR: begin
                     count_in = '0;
                     state_in = ST_FRONT_RD;
                  end
                  default: state_in = ST_FRONT_RD;
               endcase
            end
         end

         // drop when full, place directly when empty, else walk from the tail
         ST_INS_START: begin
            if (count_ff == CNT_BITS'(QUEUE_DEPTH)) begin
               status_in = STATUS_FULL;
               state_in  = ST_FRONT_RD;
            end else if (!have_front) begin
               idx_in   = '0;
               state_in = ST_INS_PLACE;
            end else begin
               idx_in   = SLOT_BITS'(count_ff - 1'b1);
               state_in = ST_INS_RD;
            end
         end

         ST_INS_RD: state_in = ST_INS_CMP;

         // move larger entries up one slot until the new one fits
         ST_INS_CMP: begin
            if (rd_data.pri > new_ff.pri) begin
               wr_req = '{en: 1'b1, addr: idx_ff + 1'b1, data: rd_data};
               if (idx_ff == '0) begin
                  state_in = ST_INS_PLACE;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = ST_INS_RD;
               end
            end else begin
               wr_req   = '{en: 1'b1, addr: idx_ff + 1'b1, data: new_ff};
               count_in = count_ff + 1'b1;
               state_in = ST_FRONT_RD;
            end
         end

         ST_INS_PLACE: begin
            wr_req   = '{en: 1'b1, addr: '0, data: new_ff};
            count_in = count_ff + 1'b1;
            state_in = ST_FRONT_RD;
         end

         ST_POP_RD: state_in = ST_POP_TAKE;

         ST_POP_TAKE: begin
            popped_in = rd_data.id;
            idx_in    = '0;
            state_in  = ST_RM;
         end

         // close the gap at idx by pulling later entries down
         ST_RM: begin
            if (last_slot) begin
               count_in = count_ff - 1'b1;
               state_in = (cmd_ff == CMD_UPGRADE) ? ST_INS_START : ST_FRONT_RD;
            end else begin
               state_in = ST_RM_WR;
            end
         end

         ST_RM_WR: begin
            wr_req   = '{en: 1'b1, addr: idx_ff, data: rd_data};
            idx_in   = idx_ff + 1'b1;
            state_in = ST_RM;
         end

         ST_SRCH_RD: state_in = ST_SRCH_CMP;

         // find the first matching id from the front
         ST_SRCH_CMP: begin
            if (rd_data.id == new_ff.id) begin
               found_in = 1'b1;
               state_in = ST_RM;
            end else if (last_slot) begin
               state_in = ST_INS_START;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SRCH_RD;
            end
         end

         ST_FRONT_RD: state_in = ST_RESP;

         ST_RESP: state_in = ST_IDLE;

         default: state_in = ST_IDLE;
      endcase
   end

   // hold control state; payload registers run free
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff    <= idx_in;
      cmd_ff    <= cmd_in;
      new_ff    <= new_in;
      popped_ff <= popped_in;
      found_ff  <= found_in;
      status_ff <= status_in;
   end

   assign busy               = state_ff != ST_IDLE;
   assign rsp_valid          = state_ff == ST_RESP;
   assign rsp_front_valid    = have_front;
   assign rsp_front_id       = have_front ? rd_data.id : '0;
   assign rsp_front_priority = have_front ? rd_data.pri : '0;
   assign rsp_popped_id      = popped_ff;
   assign rsp_occupancy      = count_ff;
   assign rsp_found          = found_ff;
   assign rsp_status         = status_ff;

`ifndef SYNTHESIS
   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_resp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && busy))
      else $error("result strobe outside a transaction");

   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy <= CNT_BITS'(QUEUE_DEPTH)))
      else $error("occupancy beyond queue depth");

   a_front_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_front_valid == (rsp_occupancy != '0)))
      else $error("front valid disagrees with occupancy");
`endif

endmodule
